// ----- sv/bkps_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bkps_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);

    localparam int KEY_W    = 3;
    localparam int BUTTON_W = 3;
    localparam int PINS_W   = 6;
    localparam int TIME_W   = 16;

    typedef logic [PTR_W-1:0]    ptr_t;
    typedef logic [KEY_W-1:0]    key_t;
    typedef logic [BUTTON_W-1:0] button_t;
    typedef logic [PINS_W-1:0]   pins_t;
    typedef logic [TIME_W-1:0]   time_t;

    localparam key_t KEY_NONE      = 3'd0;
    localparam key_t KEY_RELEASE   = 3'd1;
    localparam key_t KEY_VOLUP     = 3'd2;
    localparam key_t KEY_VOLDOWN   = 3'd3;
    localparam key_t KEY_TRACKUP   = 3'd4;
    localparam key_t KEY_TRACKDOWN = 3'd5;
    localparam key_t KEY_SOURCE    = 3'd6;
    localparam key_t KEY_PRESET    = 3'd7;

    localparam button_t BTN_NONE      = 3'd0;
    localparam button_t BTN_VOICE     = 3'd1;
    localparam button_t BTN_HANGUP    = 3'd2;
    localparam button_t BTN_TRACKUP   = 3'd3;
    localparam button_t BTN_TRACKDOWN = 3'd4;
    localparam button_t BTN_VOLUP     = 3'd5;
    localparam button_t BTN_VOLDOWN   = 3'd6;
    localparam button_t BTN_IGNORED   = 3'd7;

    localparam logic CFG_HOLD_TIME = 1'b0;
    localparam logic CFG_GAP_TIME  = 1'b1;

    localparam time_t TIME_RESET = 16'd100;

    typedef struct packed {
        logic vld0;
        key_t key0;
        logic vld1;
        key_t key1;
    } push_req_t;

    typedef struct packed {
        pins_t pins;
        key_t  started;
        logic  busy;
    } play_res_t;

    function automatic ptr_t ptr_next(input ptr_t p);
        ptr_t r;
        if (p == ptr_t'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + ptr_t'(1);
        end
        return r;
    endfunction

    function automatic pins_t key_pins(input key_t k);
        pins_t r;
        case (k)
            KEY_VOLUP:     r = 6'h01;
            KEY_VOLDOWN:   r = 6'h02;
            KEY_TRACKUP:   r = 6'h04;
            KEY_TRACKDOWN: r = 6'h08;
            KEY_SOURCE:    r = 6'h10;
            KEY_PRESET:    r = 6'h24;
            default:       r = 6'h00;
        endcase
        return r;
    endfunction

    function automatic key_t button_key(input button_t b);
        key_t r;
        case (b)
            BTN_VOICE:     r = KEY_PRESET;
            BTN_HANGUP:    r = KEY_SOURCE;
            BTN_TRACKUP:   r = KEY_TRACKUP;
            BTN_TRACKDOWN: r = KEY_TRACKDOWN;
            BTN_VOLUP:     r = KEY_VOLUP;
            BTN_VOLDOWN:   r = KEY_VOLDOWN;
            default:       r = KEY_NONE;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- sv/bkps_encoder.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bkps_encoder (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   accept,
    input  bkps_pkg::button_t     button,
    input  wire                   just_pressed,
    output bkps_pkg::push_req_t   push
);

    bkps_pkg::key_t last_reg;
    bkps_pkg::key_t last_next;
    bkps_pkg::key_t own_key;

    always_comb begin
        own_key   = bkps_pkg::button_key(button);
        push      = '0;
        last_next = last_reg;
        if (accept && just_pressed) begin
            if (button == bkps_pkg::BTN_NONE) begin
                push.vld0 = 1'b1;
                push.key0 = bkps_pkg::KEY_RELEASE;
                last_next = bkps_pkg::KEY_RELEASE;
            end else if (own_key != bkps_pkg::KEY_NONE) begin
                push.vld0 = (last_reg != bkps_pkg::KEY_RELEASE);
                push.key0 = bkps_pkg::KEY_RELEASE;
                push.vld1 = 1'b1;
                push.key1 = own_key;
                last_next = own_key;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg <= bkps_pkg::KEY_RELEASE;
        end else begin
            last_reg <= last_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/bkps_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bkps_queue (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   pop,
    input  bkps_pkg::push_req_t   push,
    output bkps_pkg::key_t        head_key,
    output logic                  empty,
    output logic                  dropped
);

    bkps_pkg::key_t mem [bkps_pkg::QUEUE_DEPTH];

    bkps_pkg::ptr_t rd_ptr_reg;
    bkps_pkg::ptr_t rd_ptr_next;
    bkps_pkg::ptr_t wr_ptr_reg;
    bkps_pkg::ptr_t wr_ptr_next;
    bkps_pkg::ptr_t wp1;
    bkps_pkg::key_t head_reg;
    logic           full0;
    logic           full1;
    logic           wr0;
    logic           wr1;

    assign empty    = (rd_ptr_reg == wr_ptr_reg);
    assign head_key = head_reg;

    // pop goes first, so pushes see the freed slot
    always_comb begin
        rd_ptr_next = pop ? bkps_pkg::ptr_next(rd_ptr_reg) : rd_ptr_reg;
        full0       = (bkps_pkg::ptr_next(wr_ptr_reg) == rd_ptr_next);
        wr0         = push.vld0 && !full0;
        wp1         = wr0 ? bkps_pkg::ptr_next(wr_ptr_reg) : wr_ptr_reg;
        full1       = (bkps_pkg::ptr_next(wp1) == rd_ptr_next);
        wr1         = push.vld1 && !full1;
        wr_ptr_next = wr1 ? bkps_pkg::ptr_next(wp1) : wp1;
        dropped     = (push.vld0 && full0) || (push.vld1 && full1);
    end

    // prefetch the next head word; forward a word written into that slot
    always_ff @(posedge aclk) begin
        for (int i = 0; i < bkps_pkg::QUEUE_DEPTH; i++) begin
            if (wr1 && (wp1 == bkps_pkg::ptr_t'(i))) begin
                mem[i] <= push.key1;
            end else if (wr0 && (wr_ptr_reg == bkps_pkg::ptr_t'(i))) begin
                mem[i] <= push.key0;
            end
        end
        if (wr0 && (wr_ptr_reg == rd_ptr_next)) begin
            head_reg <= push.key0;
        end else if (wr1 && (wp1 == rd_ptr_next)) begin
            head_reg <= push.key1;
        end else begin
            head_reg <= mem[rd_ptr_next];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/bkps_player.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bkps_player (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   accept,
    input  bkps_pkg::time_t       hold_time,
    input  bkps_pkg::time_t       gap_time,
    input  wire                   empty,
    input  bkps_pkg::key_t        head_key,
    output logic                  pop,
    output bkps_pkg::play_res_t   res
);

    logic            sending_reg;
    logic            sending_next;
    bkps_pkg::time_t delay_reg;
    bkps_pkg::time_t delay_next;
    bkps_pkg::pins_t pins_reg;
    bkps_pkg::pins_t pins_next;
    bkps_pkg::key_t  started;

    always_comb begin
        pop          = accept && !sending_reg && !empty;
        sending_next = sending_reg;
        delay_next   = delay_reg;
        pins_next    = pins_reg;
        started      = bkps_pkg::KEY_NONE;
        if (pop) begin
            started      = head_key;
            sending_next = 1'b1;
            if (head_key == bkps_pkg::KEY_RELEASE) begin
                pins_next  = '0;
                delay_next = gap_time;
            end else begin
                pins_next  = pins_reg | bkps_pkg::key_pins(head_key);
                delay_next = hold_time;
            end
        end else if (accept && sending_reg) begin
            if (delay_reg != '0) begin
                delay_next = delay_reg - bkps_pkg::time_t'(1);
            end else begin
                sending_next = 1'b0;
            end
        end
        res.pins    = pins_next;
        res.started = started;
        res.busy    = sending_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sending_reg <= 1'b0;
            delay_reg   <= '0;
            pins_reg    <= '0;
        end else begin
            sending_reg <= sending_next;
            delay_reg   <= delay_next;
            pins_reg    <= pins_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/button_key_press_sequencer.sv -----
// channel | ports                                         | handshake
// input   | s_button, s_just_pressed                      | s_valid / s_ready
// result  | m_drive_mask, m_key_started, m_busy_res, m_dropped | m_valid / m_ready
// config  | cfg_addr, cfg_wdata                           | cfg_wr_en
//
// One word in, one word out; a word per cycle if s_ready is high, result next cycle.
// Queue, timer and pin state update in the accept cycle, the result lands in m_*.
// s_ready is low only while a result sits in the output register and m_ready is low.
// Reset clears pointers, timer, pins and output valid; timing registers return to 100.
`timescale 1ns / 1ps
`default_nettype none

module button_key_press_sequencer (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      cfg_wr_en,
    input  wire                      cfg_addr,
    input  wire [15:0]               cfg_wdata,
    input  wire                      s_valid,
    output logic                     s_ready,
    input  wire [2:0]                s_button,
    input  wire                      s_just_pressed,
    output logic                     m_valid,
    input  wire                      m_ready,
    output logic [5:0]               m_drive_mask,
    output logic [2:0]               m_key_started,
    output logic                     m_busy_res,
    output logic                     m_dropped
);

    bkps_pkg::time_t     hold_reg;
    bkps_pkg::time_t     gap_reg;
    logic                accept;
    bkps_pkg::push_req_t push;
    bkps_pkg::key_t      head_key;
    logic                empty;
    logic                pop;
    logic                dropped;
    bkps_pkg::play_res_t res;

    logic                m_valid_reg;
    bkps_pkg::pins_t     mask_reg;
    bkps_pkg::key_t      started_reg;
    logic                busy_reg;
    logic                dropped_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg <= bkps_pkg::TIME_RESET;
            gap_reg  <= bkps_pkg::TIME_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                bkps_pkg::CFG_HOLD_TIME: hold_reg <= cfg_wdata;
                bkps_pkg::CFG_GAP_TIME:  gap_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    bkps_encoder u_encoder (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .button       (s_button),
        .just_pressed (s_just_pressed),
        .push         (push)
    );

    bkps_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .pop      (pop),
        .push     (push),
        .head_key (head_key),
        .empty    (empty),
        .dropped  (dropped)
    );

    bkps_player u_player (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .hold_time (hold_reg),
        .gap_time  (gap_reg),
        .empty     (empty),
        .head_key  (head_key),
        .pop       (pop),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mask_reg    <= res.pins;
            started_reg <= res.started;
            busy_reg    <= res.busy;
            dropped_reg <= dropped;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_drive_mask  = mask_reg;
    assign m_key_started = started_reg;
    assign m_busy_res    = busy_reg;
    assign m_dropped     = dropped_reg;

endmodule

`default_nettype wire

// ----- sv/bkps_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bkps_checker (
    input wire       aclk,
    input wire       aresetn,
    input wire       m_valid,
    input wire       m_ready,
    input wire [5:0] m_drive_mask,
    input wire [2:0] m_key_started,
    input wire       m_busy_res
);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_drive_mask)
            && $stable(m_key_started))
        else $error("stalled result changed");

    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_key_started != bkps_pkg::KEY_NONE) |-> m_busy_res)
        else $error("key started without busy");

    a_release_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_key_started == bkps_pkg::KEY_RELEASE) |-> (m_drive_mask == 6'd0))
        else $error("release key left pins driven");

    a_press_drives: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_key_started != bkps_pkg::KEY_NONE)
            && (m_key_started != bkps_pkg::KEY_RELEASE) |-> (m_drive_mask != 6'd0))
        else $error("pressed key drives no pin");

endmodule

bind button_key_press_sequencer bkps_checker u_bkps_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_drive_mask  (m_drive_mask),
    .m_key_started (m_key_started),
    .m_busy_res    (m_busy_res)
);

`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    import bkps_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int PRINT_CAP   = 60;

    typedef struct packed {
        pins_t mask;
        key_t  started;
        logic  busy;
        logic  dropped;
    } press_result_t;

    class press_scoreboard;
        time_t         hold_ticks;
        time_t         gap_ticks;
        key_t          ring [QUEUE_DEPTH];
        ptr_t          wr_ptr;
        ptr_t          rd_ptr;
        bit            busy;
        time_t         delay_left;
        key_t          last_key;
        pins_t         pins;
        press_result_t expected [$];
        int            mismatches;

        function new();
            hold_ticks = TIME_RESET;
            gap_ticks  = TIME_RESET;
            wr_ptr     = '0;
            rd_ptr     = '0;
            busy       = 1'b0;
            delay_left = '0;
            last_key   = KEY_RELEASE;
            pins       = '0;
            mismatches = 0;
        endfunction

        function ptr_t bump(input ptr_t p);
            return (p == ptr_t'(QUEUE_DEPTH - 1)) ? ptr_t'(0) : ptr_t'(p + 1'b1);
        endfunction

        function pins_t pins_of(input key_t k);
            case (k)
                KEY_VOLUP:     return 6'b000001;
                KEY_VOLDOWN:   return 6'b000010;
                KEY_TRACKUP:   return 6'b000100;
                KEY_TRACKDOWN: return 6'b001000;
                KEY_SOURCE:    return 6'b010000;
                KEY_PRESET:    return 6'b100100;
                default:       return 6'b000000;
            endcase
        endfunction

        function key_t key_of(input button_t b);
            case (b)
                BTN_VOICE:     return KEY_PRESET;
                BTN_HANGUP:    return KEY_SOURCE;
                BTN_TRACKUP:   return KEY_TRACKUP;
                BTN_TRACKDOWN: return KEY_TRACKDOWN;
                BTN_VOLUP:     return KEY_VOLUP;
                BTN_VOLDOWN:   return KEY_VOLDOWN;
                default:       return KEY_NONE;
            endcase
        endfunction

        // returns 1 when the queue is full and the key is lost
        function bit enqueue(input key_t k);
            ptr_t nxt;
            nxt = bump(wr_ptr);
            if (nxt == rd_ptr) begin
                return 1'b1;
            end
            ring[wr_ptr] = k;
            wr_ptr = nxt;
            return 1'b0;
        endfunction

        function void write_reg(input logic addr, input logic [15:0] data);
            if (addr == CFG_HOLD_TIME) begin
                hold_ticks = data;
            end else begin
                gap_ticks = data;
            end
        endfunction

        function void note_word(input button_t b, input logic jp);
            press_result_t r;
            key_t          k;
            key_t          own;
            bit            drop;
            drop = 1'b0;
            r.started = KEY_NONE;
            if (!busy) begin
                if (rd_ptr != wr_ptr) begin
                    k = ring[rd_ptr];
                    rd_ptr = bump(rd_ptr);
                    r.started = k;
                    if (k == KEY_RELEASE) begin
                        pins = '0;
                        delay_left = gap_ticks;
                    end else begin
                        pins = pins | pins_of(k);
                        delay_left = hold_ticks;
                    end
                    busy = 1'b1;
                end
            end else if (delay_left != '0) begin
                delay_left = delay_left - 1'b1;
            end else begin
                busy = 1'b0;
            end
            if (jp) begin
                if (b == BTN_NONE) begin
                    drop = enqueue(KEY_RELEASE) | drop;
                    last_key = KEY_RELEASE;
                end else begin
                    own = key_of(b);
                    if (own != KEY_NONE) begin
                        if (last_key != KEY_RELEASE) begin
                            drop = enqueue(KEY_RELEASE) | drop;
                        end
                        drop = enqueue(own) | drop;
                        last_key = own;
                    end
                end
            end
            r.mask    = pins;
            r.busy    = busy;
            r.dropped = drop;
            expected.push_back(r);
        endfunction

        function int waiting();
            return expected.size();
        endfunction

        task report_mismatch(input string msg);
            if (mismatches < PRINT_CAP) begin
                $display("[%0t] mismatch: %s", $realtime, msg);
            end
            mismatches++;
        endtask

        task check_word(input pins_t mask, input key_t started, input logic bsy,
                        input logic dropped);
            press_result_t e;
            if (expected.size() == 0) begin
                report_mismatch("result word with nothing pending");
            end else begin
                e = expected.pop_front();
                if (mask !== e.mask) begin
                    report_mismatch($sformatf("drive_mask %0h, want %0h", mask, e.mask));
                end
                if (started !== e.started) begin
                    report_mismatch($sformatf("key_started %0d, want %0d", started,
                                              e.started));
                end
                if (bsy !== e.busy) begin
                    report_mismatch($sformatf("busy_res %0b, want %0b", bsy, e.busy));
                end
                if (dropped !== e.dropped) begin
                    report_mismatch($sformatf("dropped %0b, want %0b", dropped,
                                              e.dropped));
                end
            end
        endtask
    endclass

    logic          aclk;
    logic          aresetn        = 1'b0;
    logic          cfg_wr_en      = 1'b0;
    logic          cfg_addr       = 1'b0;
    logic [15:0]   cfg_wdata      = '0;
    logic          s_valid        = 1'b0;
    logic          s_ready;
    button_t       s_button       = BTN_NONE;
    logic          s_just_pressed = 1'b0;
    logic          m_valid;
    logic          m_ready        = 1'b0;
    pins_t         m_drive_mask;
    key_t          m_key_started;
    logic          m_busy_res;
    logic          m_dropped;

    press_scoreboard sb = new();
    int              words_sent  = 0;
    int              cycle_count = 0;

    button_key_press_sequencer u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_button       (s_button),
        .s_just_pressed (s_just_pressed),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_drive_mask   (m_drive_mask),
        .m_key_started  (m_key_started),
        .m_busy_res     (m_busy_res),
        .m_dropped      (m_dropped)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en) begin
                sb.write_reg(cfg_addr, cfg_wdata);
            end
            if (m_valid && m_ready) begin
                sb.check_word(m_drive_mask, m_key_started, m_busy_res, m_dropped);
            end
            if (s_valid && s_ready) begin
                sb.note_word(s_button, s_just_pressed);
            end
        end
    end

    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 80);
    endfunction

    task automatic send_word(input button_t b, input logic jp);
        int idle;
        idle = pick_idle();
        if (idle > 0) begin
            s_valid <= 1'b0;
            repeat (idle) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_button       <= b;
        s_just_pressed <= jp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
    endtask

    task automatic set_timing(input time_t hold, input time_t gap);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_HOLD_TIME;
        cfg_wdata <= hold;
        @(posedge aclk);
        cfg_addr  <= CFG_GAP_TIME;
        cfg_wdata <= gap;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (sb.waiting() != 0) @(negedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic press_and_release();
        button_t b;
        int      n;
        if ($urandom_range(0, 99) < 85) begin
            b = button_t'($urandom_range(1, 6));
        end else begin
            b = button_t'($urandom_range(0, 7));
        end
        send_word(b, 1'b1);
        n = $urandom_range(0, 6);
        repeat (n) send_word(b, 1'b0);
        send_word(BTN_NONE, 1'b1);
        n = $urandom_range(0, 4);
        repeat (n) send_word(BTN_NONE, 1'b0);
    endtask

    task automatic random_phase(input int count);
        int goal;
        int r;
        int n;
        goal = words_sent + count;
        while (words_sent < goal) begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                press_and_release();
            end else if (r < 80) begin
                n = $urandom_range(2, 8);
                repeat (n) send_word(button_t'($urandom_range(1, 7)), 1'b1);
            end else begin
                n = $urandom_range(1, 6);
                repeat (n) send_word(button_t'($urandom_range(0, 7)), 1'($urandom));
            end
        end
    endtask

    initial begin : sink
        int n;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            n = $urandom_range(0, 99);
            if (n < 55) begin
                n = 0;
            end else if (n < 90) begin
                n = $urandom_range(1, 3);
            end else if (n < 98) begin
                n = $urandom_range(4, 15);
            end else begin
                n = $urandom_range(30, 80);
            end
            if (n > 0) begin
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge aclk);
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        time_t hold;
        time_t gap;
        int    count;
        int    i;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_word(BTN_NONE, 1'b1);
        send_word(BTN_VOICE, 1'b1);
        send_word(BTN_HANGUP, 1'b1);
        send_word(BTN_TRACKUP, 1'b1);
        send_word(BTN_TRACKDOWN, 1'b1);
        send_word(BTN_VOLUP, 1'b1);
        send_word(BTN_VOLDOWN, 1'b1);
        send_word(BTN_IGNORED, 1'b1);
        send_word(BTN_IGNORED, 1'b0);
        send_word(BTN_TRACKUP, 1'b0);
        for (i = 0; i < 12; i++) begin
            send_word(button_t'(1 + (i % 6)), 1'b1);
        end

        for (i = 0; i < 8; i++) begin
            count = 170;
            case (i)
                0: begin hold = 16'd0;     gap = 16'd0; end
                1: begin hold = 16'd1;     gap = 16'd0; end
                2: begin hold = 16'd0;     gap = 16'd1; end
                3: begin hold = 16'd2;     gap = 16'd3; end
                4: begin
                    hold = time_t'($urandom_range(0, 7));
                    gap  = time_t'($urandom_range(0, 7));
                end
                5: begin
                    hold = time_t'($urandom_range(10, 40));
                    gap  = time_t'($urandom_range(10, 40));
                end
                6: begin
                    hold = time_t'($urandom_range(0, 3));
                    gap  = time_t'($urandom_range(0, 3));
                end
                default: begin
                    hold  = 16'hFFFF;
                    gap   = 16'hFFFF;
                    count = 120;
                end
            endcase
            drain();
            set_timing(hold, gap);
            random_phase(count);
        end

        drain();
        repeat (10) @(posedge aclk);
        if (sb.mismatches == 0 && sb.waiting() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/bkps_pkg.sv
sv/bkps_encoder.sv
sv/bkps_queue.sv
sv/bkps_player.sv
sv/button_key_press_sequencer.sv
sv/bkps_checker.sv
verif/testbench.sv
